[hw/rtl/fcd_pkg.sv]
// Shared types, constants and helper functions for the FAST corner detector.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package fcd_pkg;

    // Geometry of the neighborhood
    localparam int WIN       = 7;
    localparam int LINES     = 6;
    localparam int RADIUS    = 3;
    localparam int CIRCLE_N  = 16;
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int COORD_W   = 10;
    localparam int SLOT_W    = 3;
    localparam int ARC_W     = 5;
    localparam int LINE_W    = LINES * PIX_W;

    // Limits on the effective frame size and arc length
    localparam logic [DIM_W-1:0] MIN_DIM    = 11'd7;
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;
    localparam logic [ARC_W-1:0] ARC_MIN    = 5'd9;
    localparam logic [ARC_W-1:0] ARC_MAX    = 5'd16;

    // Register reset values
    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd20;
    localparam logic [DIM_W-1:0] WIDTH_RST     = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST    = 11'd480;
    localparam logic [ARC_W-1:0] ARC_RST       = 5'd12;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_ARC_LENGTH   = 2'd3
    } reg_idx_t;

    // Window row and column of each circle point, clockwise from the top
    localparam logic [2:0] CIRC_ROW [CIRCLE_N] = '{
        3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };
    localparam logic [2:0] CIRC_COL [CIRCLE_N] = '{
        3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
        3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2
    };

    typedef struct packed {
        logic [PIX_W-1:0] threshold;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [ARC_W-1:0] arc_length;
    } cfg_t;

    // Per-word bookkeeping that travels with the pixel down the pipe
    typedef struct packed {
        logic               center_valid;
        logic               check;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } meta_t;

    typedef struct packed {
        meta_t             meta;
        logic [SLOT_W-1:0] slot;
        logic [PIX_W-1:0]  pixel;
    } s1_t;

    typedef struct packed {
        meta_t               meta;
        logic [CIRCLE_N-1:0] bright;
        logic [CIRCLE_N-1:0] dark;
    } s3_t;

    // True if the 16-bit ring mask holds a cyclic run of at least arc ones
    function automatic logic has_arc(logic [CIRCLE_N-1:0] m, logic [ARC_W-1:0] arc);
        logic [2*CIRCLE_N-1:0] mm;
        logic [CIRCLE_N-1:0]   need;
        logic [CIRCLE_N-1:0]   seg;
        logic                  hit;
        mm   = {m, m};
        need = CIRCLE_N'((17'd1 << arc) - 17'd1);
        hit  = 1'b0;
        for (int i = 0; i < CIRCLE_N; i++) begin
            seg = mm[i +: CIRCLE_N];
            hit = hit | (&(seg | ~need));
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/fcd_pixel_if.sv]
// Input channel of the corner detector: one grey pixel word per handshake.
// Depends on fcd_pkg for field widths.
`default_nettype none

interface fcd_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [fcd_pkg::PIX_W-1:0]   pixel;
    logic                        frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

[hw/rtl/fcd_result_if.sv]
// Output channel of the corner detector: one result word per handshake.
// Depends on fcd_pkg for field widths.
`default_nettype none

interface fcd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          center_valid;
    logic                          is_corner;
    logic                          dark_corner;
    logic [fcd_pkg::COORD_W-1:0]   center_x;
    logic [fcd_pkg::COORD_W-1:0]   center_y;

    modport source (output valid, output center_valid, output is_corner,
                    output dark_corner, output center_x, output center_y, input ready);
    modport sink   (input valid, input center_valid, input is_corner,
                    input dark_corner, input center_x, input center_y, output ready);
endinterface

`default_nettype wire

[hw/rtl/fcd_front.sv]
// Front stage: raster counters, the six-row line store memory and its clear pass.
// Depends on fcd_pkg (cfg_t, s1_t, geometry constants).
`default_nettype none

module fcd_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire fcd_pkg::cfg_t                    cfg,
    input  wire logic                             in_valid,
    input  wire logic [fcd_pkg::PIX_W-1:0]        in_pixel,
    input  wire logic                             in_frame_start,
    output logic                                  in_ready,
    output logic                                  s1_valid,
    input  wire logic                             s1_ready,
    output fcd_pkg::s1_t                          s1_data,
    output logic [fcd_pkg::LINE_W-1:0]            col_data,
    output logic                                  clearing
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WW0 > fcd_pkg::DIM_W) ? WW0 : fcd_pkg::DIM_W;
    localparam logic [WW-1:0] MAX_W    = WW'(MAX_WIDTH);
    localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);
    localparam logic [fcd_pkg::SLOT_W-1:0] LAST_SLOT = fcd_pkg::SLOT_W'(fcd_pkg::LINES - 1);

    // One entry per column, one byte lane per buffered row
    logic [fcd_pkg::LINE_W-1:0] mem [MAX_WIDTH];

    logic [CW-1:0]                  col_reg, col_next;
    logic [fcd_pkg::COORD_W-1:0]    row_reg, row_next;
    logic [fcd_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic                           clr_reg;
    logic [CW-1:0]                  clr_addr_reg;
    logic                           s1_valid_reg;
    fcd_pkg::s1_t                   s1_reg;
    logic [fcd_pkg::LINE_W-1:0]     rd_reg;

    logic [WW-1:0]                  width_eff;
    logic [fcd_pkg::DIM_W-1:0]      height_eff;
    logic [WW-1:0]                  x_w;
    logic [CW-1:0]                  x;
    logic [fcd_pkg::COORD_W-1:0]    y;
    logic [fcd_pkg::SLOT_W-1:0]     slot_cur;
    logic [WW-1:0]                  x_inc;
    logic [fcd_pkg::DIM_W-1:0]      y_inc;
    logic                           acc;
    fcd_pkg::meta_t                 meta;

    // Clamp frame size to the supported range
    always_comb
    begin
        width_eff = WW'(cfg.image_width);
        if (width_eff < WW'(fcd_pkg::MIN_DIM))
        begin
            width_eff = WW'(fcd_pkg::MIN_DIM);
        end
        else if (width_eff > MAX_W)
        begin
            width_eff = MAX_W;
        end
        height_eff = cfg.image_height;
        if (height_eff < fcd_pkg::MIN_DIM)
        begin
            height_eff = fcd_pkg::MIN_DIM;
        end
        else if (height_eff > fcd_pkg::MAX_HEIGHT)
        begin
            height_eff = fcd_pkg::MAX_HEIGHT;
        end
    end

    assign in_ready = !clr_reg && (!s1_valid_reg || s1_ready);
    assign acc      = in_valid && in_ready;

    // Position of the incoming pixel and counter advance
    always_comb
    begin
        x_w      = WW'(col_reg);
        y        = row_reg;
        slot_cur = slot_reg;
        if (in_frame_start)
        begin
            x_w      = '0;
            y        = '0;
            slot_cur = '0;
        end
        if (x_w >= width_eff)
        begin
            x_w = '0;
        end
        if (fcd_pkg::DIM_W'(y) >= height_eff)
        begin
            y        = '0;
            slot_cur = '0;
        end
        x = x_w[CW-1:0];

        x_inc     = x_w + WW'(1);
        y_inc     = fcd_pkg::DIM_W'(y) + fcd_pkg::DIM_W'(1);
        col_next  = x_inc[CW-1:0];
        row_next  = y;
        slot_next = slot_cur;
        if (x_inc >= width_eff)
        begin
            col_next = '0;
            if (y_inc >= height_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = y_inc[fcd_pkg::COORD_W-1:0];
                slot_next = (slot_cur == LAST_SLOT) ? '0 : slot_cur + 1'b1;
            end
        end

        meta.center_valid = (x_w >= WW'(fcd_pkg::RADIUS)) &&
                            (y >= fcd_pkg::COORD_W'(fcd_pkg::RADIUS));
        meta.check        = (x_w >= WW'(2 * fcd_pkg::RADIUS)) &&
                            (y >= fcd_pkg::COORD_W'(2 * fcd_pkg::RADIUS));
        meta.cx           = '0;
        meta.cy           = '0;
        if (meta.center_valid)
        begin
            meta.cx = fcd_pkg::COORD_W'(x_w - WW'(fcd_pkg::RADIUS));
            meta.cy = y - fcd_pkg::COORD_W'(fcd_pkg::RADIUS);
        end
    end

    // Counters, clear pass and stage-1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_COL)
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (acc)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
            if (!s1_valid_reg || s1_ready)
            begin
                s1_valid_reg <= acc;
            end
        end
    end

    // Hold the word payload for stage 1
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg.meta  <= meta;
            s1_reg.slot  <= slot_cur;
            s1_reg.pixel <= in_pixel;
        end
    end

    // Line store: read the column before this pixel replaces its oldest row
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (acc)
        begin
            for (int l = 0; l < fcd_pkg::LINES; l++)
            begin
                if (slot_cur == fcd_pkg::SLOT_W'(l))
                begin
                    mem[x][l*fcd_pkg::PIX_W +: fcd_pkg::PIX_W] <= in_pixel;
                end
            end
        end
        if (acc)
        begin
            rd_reg <= mem[x];
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_reg;
    assign col_data = rd_reg;
    assign clearing = clr_reg;

endmodule

`default_nettype wire

[hw/rtl/fcd_window.sv]
// Window stage: 7x7 pixel window fed from the line store, then the circle compares.
// Depends on fcd_pkg (s1_t, s3_t, circle tables).
`default_nettype none

module fcd_window (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [fcd_pkg::PIX_W-1:0]        threshold,
    input  wire logic                             s1_valid,
    output logic                                  s1_ready,
    input  wire fcd_pkg::s1_t                     s1_data,
    input  wire logic [fcd_pkg::LINE_W-1:0]       col_data,
    output logic                                  s3_valid,
    input  wire logic                             s3_ready,
    output fcd_pkg::s3_t                          s3_data
);

    logic [fcd_pkg::PIX_W-1:0] win_reg [fcd_pkg::WIN][fcd_pkg::WIN];
    logic                      v2_reg;
    fcd_pkg::meta_t            meta2_reg;
    logic                      v3_reg;
    fcd_pkg::s3_t              s3_reg;

    logic [fcd_pkg::PIX_W-1:0] new_col [fcd_pkg::WIN];
    logic                      s3_free;
    logic                      s2_free;
    logic                      load2;
    logic                      load3;
    fcd_pkg::s3_t              s3_next;

    assign s3_free  = !v3_reg || s3_ready;
    assign s2_free  = !v2_reg || s3_free;
    assign s1_ready = s2_free;
    assign load2    = s1_valid && s2_free;
    assign load3    = v2_reg && s3_free;

    // Rotate the line store lanes so the oldest row lands on top
    always_comb
    begin
        logic [3:0] lane;
        for (int k = 0; k < fcd_pkg::LINES; k++)
        begin
            lane = 4'(s1_data.slot) + 4'(k);
            if (lane >= 4'(fcd_pkg::LINES))
            begin
                lane = lane - 4'(fcd_pkg::LINES);
            end
            new_col[k] = col_data[lane*fcd_pkg::PIX_W +: fcd_pkg::PIX_W];
        end
        new_col[fcd_pkg::WIN-1] = s1_data.pixel;
    end

    // Compare each circle point against center plus and minus threshold
    always_comb
    begin
        logic [fcd_pkg::PIX_W:0] ctr;
        logic [fcd_pkg::PIX_W:0] p;
        logic [fcd_pkg::PIX_W:0] thr;
        ctr = {1'b0, win_reg[fcd_pkg::RADIUS][fcd_pkg::RADIUS]};
        thr = {1'b0, threshold};
        s3_next.meta = meta2_reg;
        for (int k = 0; k < fcd_pkg::CIRCLE_N; k++)
        begin
            p = {1'b0, win_reg[fcd_pkg::CIRC_ROW[k]][fcd_pkg::CIRC_COL[k]]};
            s3_next.bright[k] = meta2_reg.check && (p > ctr + thr);
            s3_next.dark[k]   = meta2_reg.check && (ctr > p + thr);
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                v2_reg <= s1_valid;
            end
            if (s3_free)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Shift the window left and insert the new column; hold the masks
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            for (int r = 0; r < fcd_pkg::WIN; r++)
            begin
                for (int c = 0; c < fcd_pkg::WIN - 1; c++)
                begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
                win_reg[r][fcd_pkg::WIN-1] <= new_col[r];
            end
            meta2_reg <= s1_data.meta;
        end
        if (load3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3_valid = v3_reg;
    assign s3_data  = s3_reg;

endmodule

`default_nettype wire

[hw/rtl/fcd_arc_out.sv]
// Output stage: cyclic arc test on the compare masks and the result register.
// Depends on fcd_pkg (s3_t, has_arc, arc limits).
`default_nettype none

module fcd_arc_out (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [fcd_pkg::ARC_W-1:0]        arc_length,
    input  wire logic                             s3_valid,
    output logic                                  s3_ready,
    input  wire fcd_pkg::s3_t                     s3_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  center_valid,
    output logic                                  is_corner,
    output logic                                  dark_corner,
    output logic [fcd_pkg::COORD_W-1:0]           center_x,
    output logic [fcd_pkg::COORD_W-1:0]           center_y
);

    logic                         vo_reg;
    logic                         cv_reg;
    logic                         corner_reg;
    logic                         dark_reg;
    logic [fcd_pkg::COORD_W-1:0]  cx_reg;
    logic [fcd_pkg::COORD_W-1:0]  cy_reg;

    logic [fcd_pkg::ARC_W-1:0]    arc_eff;
    logic                         hit_bright;
    logic                         hit_dark;
    logic                         take;

    assign take     = !vo_reg || out_ready;
    assign s3_ready = take;

    // Clamp arc length and run the ring tests
    always_comb
    begin
        arc_eff = arc_length;
        if (arc_eff < fcd_pkg::ARC_MIN)
        begin
            arc_eff = fcd_pkg::ARC_MIN;
        end
        else if (arc_eff > fcd_pkg::ARC_MAX)
        begin
            arc_eff = fcd_pkg::ARC_MAX;
        end
        hit_bright = fcd_pkg::has_arc(s3_data.bright, arc_eff);
        hit_dark   = fcd_pkg::has_arc(s3_data.dark, arc_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (take)
        begin
            vo_reg <= s3_valid;
        end
    end

    // Load the result word; brighter arc wins over darker
    always_ff @(posedge clk)
    begin
        if (take && s3_valid)
        begin
            cv_reg     <= s3_data.meta.center_valid;
            corner_reg <= hit_bright || hit_dark;
            dark_reg   <= !hit_bright && hit_dark;
            cx_reg     <= s3_data.meta.cx;
            cy_reg     <= s3_data.meta.cy;
        end
    end

    assign out_valid    = vo_reg;
    assign center_valid = cv_reg;
    assign is_corner    = corner_reg;
    assign dark_corner  = dark_reg;
    assign center_x     = cx_reg;
    assign center_y     = cy_reg;

endmodule

`default_nettype wire

[hw/rtl/fast_corner_detect.sv]
// FAST-12 style corner detector: one result word per pixel word, for the center 3 back.
// Stages: line store read, window shift, circle compare and arc test, each registered,
// feed the result port. Throughput: one word per cycle while the result side is ready,
// set by the single-port line store read and write that each pixel does in its accept cycle.
// Reset: registers take their reset values, then a clear pass zeroes the line store,
// one column per cycle across all MAX_WIDTH columns, with the input held not ready.
`default_nettype none

module fast_corner_detect #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    fcd_pixel_if.sink                         pix_in,
    fcd_result_if.source                      res_out,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [fcd_pkg::DIM_W-1:0]    cfg_data
);

    fcd_pkg::cfg_t                cfg_reg;
    logic                         s1_valid;
    logic                         s1_ready;
    fcd_pkg::s1_t                 s1_data;
    logic [fcd_pkg::LINE_W-1:0]   col_data;
    logic                         clearing;
    logic                         s3_valid;
    logic                         s3_ready;
    fcd_pkg::s3_t                 s3_data;
    logic                         in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= fcd_pkg::THRESHOLD_RST;
            cfg_reg.image_width  <= fcd_pkg::WIDTH_RST;
            cfg_reg.image_height <= fcd_pkg::HEIGHT_RST;
            cfg_reg.arc_length   <= fcd_pkg::ARC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fcd_pkg::REG_THRESHOLD:
                    cfg_reg.threshold <= cfg_data[fcd_pkg::PIX_W-1:0];
                fcd_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width <= cfg_data;
                fcd_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= cfg_data;
                fcd_pkg::REG_ARC_LENGTH:
                    cfg_reg.arc_length <= cfg_data[fcd_pkg::ARC_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    fcd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (pix_in.valid),
        .in_pixel       (pix_in.pixel),
        .in_frame_start (pix_in.frame_start),
        .in_ready       (in_ready),
        .s1_valid       (s1_valid),
        .s1_ready       (s1_ready),
        .s1_data        (s1_data),
        .col_data       (col_data),
        .clearing       (clearing)
    );

    assign pix_in.ready = in_ready;

    fcd_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (cfg_reg.threshold),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_data   (s1_data),
        .col_data  (col_data),
        .s3_valid  (s3_valid),
        .s3_ready  (s3_ready),
        .s3_data   (s3_data)
    );

    fcd_arc_out u_arc_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .arc_length   (cfg_reg.arc_length),
        .s3_valid     (s3_valid),
        .s3_ready     (s3_ready),
        .s3_data      (s3_data),
        .out_valid    (res_out.valid),
        .out_ready    (res_out.ready),
        .center_valid (res_out.center_valid),
        .is_corner    (res_out.is_corner),
        .dark_corner  (res_out.dark_corner),
        .center_x     (res_out.center_x),
        .center_y     (res_out.center_y)
    );

    // No pixel enters while the line store is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("pixel accepted during line store clear");

    // A frame start puts the pixel at column zero, so it reports no center
    a_frame_start_no_center: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && in_ready && pix_in.frame_start) |=> !s1_data.meta.center_valid)
        else $error("frame start pixel produced a center");

    // A corner is only flagged on a reported center away from the border
    a_corner_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.is_corner) |->
            (res_out.center_valid &&
             res_out.center_x >= fcd_pkg::COORD_W'(fcd_pkg::RADIUS) &&
             res_out.center_y >= fcd_pkg::COORD_W'(fcd_pkg::RADIUS)))
        else $error("corner flagged at border or without center");

    // A dark flag never appears when the dark mask has no bit set
    a_dark_implies_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid && s3_ready && s3_data.dark == '0) |=> !res_out.dark_corner)
        else $error("dark corner without dark mask");

endmodule

`default_nettype wire

[verif/tb_fast_corner_detect.sv]
// Testbench for the FAST corner detector: streams pixel words with random gaps and
// result stalls, predicts each result word or takes it from a directed row, and checks each one field by field.
// Depends on fcd_pkg, fcd_pixel_if, fcd_result_if and the fast_corner_detect top.

module tb_fast_corner_detect;
    import fcd_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int RANDOM_WORDS = 2000;
    localparam int LINE_DEPTH   = 1024;
    localparam int HEIGHT_MAX   = 1024;
    localparam int BIG_PHASE    = 2;
    localparam int FRAME_CAP    = 600;
    localparam int SETTLE       = 12;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic               cv;
        logic               corner;
        logic               dark;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } result_word_t;

    typedef enum logic { ROW_PIX, ROW_CFG } row_kind_t;
    typedef enum int { PAT_NOISE, PAT_DOTS, PAT_RECT } pattern_t;

    typedef struct packed {
        row_kind_t        kind;
        reg_idx_t         idx;
        logic [DIM_W-1:0] data;
        logic [11:0]      count;
        logic [PIX_W-1:0] pix;
        logic             fs;
        logic             typed;
        result_word_t     want;
    } stim_row_t;

    localparam result_word_t NO_CENTER  = '0;
    localparam result_word_t DOT_CORNER = '{1'b1, 1'b1, 1'b1, 10'd3, 10'd3};

    // Directed rows; pixel rows with typed set carry their own expected word
    localparam int N_DIRECTED = 20;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // reset frame size: top rows report no center
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd3, 8'h00, 1'b1, 1'b1, NO_CENTER},
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1, 8'hFF, 1'b0, 1'b1, NO_CENTER},
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1, 8'h55, 1'b0, 1'b1, NO_CENTER},
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1, 8'hAA, 1'b0, 1'b1, NO_CENTER},
        // frame start in the middle of a row
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1, 8'h80, 1'b1, 1'b1, NO_CENTER},
        // registers out of range clamp to their limits
        '{ROW_CFG, REG_THRESHOLD,    11'h7FF, 12'd0, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_CFG, REG_IMAGE_WIDTH,  11'd2047, 12'd0, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 11'd0,   12'd0, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_CFG, REG_ARC_LENGTH,   11'd31,  12'd0, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1, 8'h01, 1'b1, 1'b1, NO_CENTER},
        // smallest frame, lowest arc and threshold
        '{ROW_CFG, REG_IMAGE_WIDTH,  11'd0, 12'd0, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 11'd7, 12'd0, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_CFG, REG_THRESHOLD,    11'd0, 12'd0, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_CFG, REG_ARC_LENGTH,   11'd0, 12'd0, 8'h00, 1'b0, 1'b0, NO_CENTER},
        // one bright dot at (3,3) on black gives a dark corner
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1,  8'h00, 1'b1, 1'b1, NO_CENTER},
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd23, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1,  8'hFF, 1'b0, 1'b0, NO_CENTER},
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd23, 8'h00, 1'b0, 1'b0, NO_CENTER},
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1,  8'h00, 1'b0, 1'b1, DOT_CORNER},
        // counters wrap back to the first pixel
        '{ROW_PIX, REG_THRESHOLD, 11'd0, 12'd1,  8'h00, 1'b0, 1'b1, NO_CENTER}
    };

    // Radius-3 ring, clockwise from the top
    localparam int RING_DY [16] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
    localparam int RING_DX [16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [DIM_W-1:0] cfg_data;

    fcd_pixel_if  pix_bus ();
    fcd_result_if res_bus ();

    fast_corner_detect #(.MAX_WIDTH(LINE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_bus),
        .res_out   (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the detector: line store, window, position and registers
    logic [PIX_W-1:0] line_mem [LINES][LINE_DEPTH];
    logic [PIX_W-1:0] win [WIN][WIN];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [7:0]       sh_thr;
    logic [10:0]      sh_width;
    logic [10:0]      sh_height;
    logic [4:0]       sh_arc;

    result_word_t reports_due [$];

    int  failures;
    int  words_sent;
    int  random_words;
    int  results_seen;
    int  bright_seen;
    int  dark_seen;
    int  phases_run;
    bit  tx_steady;
    bit  rx_steady;
    int  stall_left;
    int  cycles;

    // Frame pattern state
    pattern_t    pat;
    int          bg_level;
    int          lo_level;
    int          hi_level;
    int unsigned rect_x0, rect_x1, rect_y0, rect_y1;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Scan twice round the ring for a run of ones at least need long
    function automatic logic ring_has_run(logic [15:0] m, int unsigned need);
        int unsigned run;
        run = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i % 16])
            begin
                run++;
                if (run >= need)
                    return 1'b1;
            end
            else
                run = 0;
        end
        return 1'b0;
    endfunction

    task automatic reset_shadow();
        for (int s = 0; s < LINES; s++)
            for (int c = 0; c < LINE_DEPTH; c++)
                line_mem[s][c] = '0;
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN; c++)
                win[r][c] = '0;
        col_pos   = 0;
        row_pos   = 0;
        sh_thr    = 8'd20;
        sh_width  = 11'd640;
        sh_height = 11'd480;
        sh_arc    = 5'd12;
    endtask

    task automatic mirror_reg(input reg_idx_t idx, input logic [DIM_W-1:0] d);
        case (idx)
            REG_THRESHOLD:    sh_thr    = d[7:0];
            REG_IMAGE_WIDTH:  sh_width  = d;
            REG_IMAGE_HEIGHT: sh_height = d;
            REG_ARC_LENGTH:   sh_arc    = d[4:0];
            default: ;
        endcase
    endtask

    // Advance the shadow by one pixel and return the word it reports
    function automatic result_word_t detect_next(logic [PIX_W-1:0] pix, logic fs);
        int unsigned  w, h, need, x, y, slot, cx, cy;
        int           ctr, p;
        logic [15:0]  brighter, darker;
        result_word_t r;
        w    = clamp_to(sh_width, 7, LINE_DEPTH);
        h    = clamp_to(sh_height, 7, HEIGHT_MAX);
        need = clamp_to(sh_arc, 9, 16);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        x = col_pos;
        y = row_pos;

        // shift the window left and load the new column
        for (int rr = 0; rr < WIN; rr++)
            for (int cc = 0; cc < WIN - 1; cc++)
                win[rr][cc] = win[rr][cc + 1];
        slot = y % LINES;
        for (int k = 0; k < LINES; k++)
            win[k][WIN - 1] = line_mem[(slot + k) % LINES][x];
        win[WIN - 1][WIN - 1] = pix;
        line_mem[slot][x]     = pix;

        r = NO_CENTER;
        if (x >= RADIUS && y >= RADIUS)
        begin
            cx   = x - RADIUS;
            cy   = y - RADIUS;
            r.cv = 1'b1;
            r.cx = COORD_W'(cx);
            r.cy = COORD_W'(cy);
            // centers next to the border never flag
            if (cx >= RADIUS && cy >= RADIUS)
            begin
                ctr      = int'(win[RADIUS][RADIUS]);
                brighter = '0;
                darker   = '0;
                for (int k = 0; k < 16; k++)
                begin
                    p = int'(win[RADIUS + RING_DY[k]][RADIUS + RING_DX[k]]);
                    if (p - ctr > int'(sh_thr))
                        brighter[k] = 1'b1;
                    if (ctr - p > int'(sh_thr))
                        darker[k] = 1'b1;
                end
                if (ring_has_run(brighter, need))
                    r.corner = 1'b1;
                else if (ring_has_run(darker, need))
                begin
                    r.corner = 1'b1;
                    r.dark   = 1'b1;
                end
            end
        end

        col_pos = x + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return 1;
        if (r < 96)
            return $urandom_range(2, 5);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] jitter(int base, int amt);
        int v;
        v = base + int'($urandom_range(0, 2 * amt)) - amt;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return PIX_W'(v);
    endfunction

    task automatic pick_pattern(input int unsigned w, input int unsigned h);
        int r;
        r = $urandom_range(0, 99);
        pat      = (r < 30) ? PAT_NOISE : (r < 65) ? PAT_DOTS : PAT_RECT;
        bg_level = $urandom_range(60, 190);
        lo_level = $urandom_range(0, 100);
        hi_level = $urandom_range(150, 255);
        if ($urandom_range(0, 1))
        begin
            r        = lo_level;
            lo_level = hi_level;
            hi_level = r;
        end
        rect_x0 = $urandom_range(0, w - 1);
        rect_x1 = rect_x0 + $urandom_range(2, w);
        rect_y0 = $urandom_range(0, (h > 20 ? 20 : h) - 1);
        rect_y1 = rect_y0 + $urandom_range(2, 12);
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(int unsigned x, int unsigned y);
        case (pat)
            PAT_NOISE:
                return PIX_W'($urandom);
            PAT_DOTS:
            begin
                if ($urandom_range(0, 11) == 0)
                    return $urandom_range(0, 1) ? PIX_W'($urandom_range(225, 255))
                                                : PIX_W'($urandom_range(0, 30));
                return jitter(bg_level, 3);
            end
            default:
            begin
                if (x >= rect_x0 && x <= rect_x1 && y >= rect_y0 && y <= rect_y1)
                    return jitter(hi_level, 2);
                return jitter(lo_level, 2);
            end
        endcase
    endfunction

    // Offer one pixel word, hold it until taken, then log what it must produce
    task automatic send_word(input logic [PIX_W-1:0] pix, input logic fs,
                             input logic typed, input result_word_t want);
        int           gap;
        result_word_t pred;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel       <= pix;
        pix_bus.frame_start <= fs;
        do
            @(posedge clk);
        while (pix_bus.ready !== 1'b1);
        pred = detect_next(pix, fs);
        reports_due.insert(reports_due.size(), typed ? want : pred);
        words_sent++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        mirror_reg(idx, d);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait until every pending word has come out
    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // New register setting, then one or more frames of one pattern each
    task automatic run_phase(input int pno);
        logic [DIM_W-1:0] thr_d, wid_d, hgt_d, arc_d;
        int unsigned      w, h, cap, frames, r, x, y;
        logic             fs;
        drain_results();
        r     = $urandom_range(0, 99);
        thr_d = {3'($urandom), (r < 10) ? 8'd0 : (r < 20) ? 8'd255
                                               : 8'($urandom_range(0, 60))};
        if (pno == BIG_PHASE)
        begin
            wid_d = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
            hgt_d = 11'd7;
        end
        else
        begin
            r     = $urandom_range(0, 99);
            wid_d = (r < 4) ? 11'($urandom_range(0, 6)) : (r < 10) ? 11'd7
                                                        : 11'($urandom_range(7, 24));
            r     = $urandom_range(0, 99);
            hgt_d = (r < 3) ? 11'($urandom_range(1020, 2047))
                  : (r < 6) ? 11'($urandom_range(0, 6))
                  : (r < 12) ? 11'd7 : 11'($urandom_range(7, 14));
        end
        r     = $urandom_range(0, 99);
        arc_d = {6'($urandom), (r < 8) ? 5'($urandom_range(0, 31)) : (r < 16) ? 5'd9
                             : (r < 24) ? 5'd16 : 5'($urandom_range(9, 16))};
        write_reg(REG_THRESHOLD, thr_d);
        write_reg(REG_IMAGE_WIDTH, wid_d);
        write_reg(REG_IMAGE_HEIGHT, hgt_d);
        write_reg(REG_ARC_LENGTH, arc_d);

        tx_steady = ($urandom_range(0, 3) == 0);
        w      = clamp_to(wid_d, 7, LINE_DEPTH);
        h      = clamp_to(hgt_d, 7, HEIGHT_MAX);
        cap    = (pno == BIG_PHASE) ? w + 40 : ((w * h > FRAME_CAP) ? FRAME_CAP : w * h);
        frames = (pno == BIG_PHASE) ? 1 : $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
        begin
            pick_pattern(w, h);
            for (int unsigned n = 0; n < cap; n++)
            begin
                x  = n % w;
                y  = n / w;
                // mostly a clean frame start, sometimes left to the counter wrap
                fs = (n == 0) && ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 299) == 0)
                    fs = 1'b1;
                send_word(make_pixel(x, y), fs, 1'b0, NO_CENTER);
                random_words++;
            end
        end
        phases_run++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d words still pending", cycles,
                 reports_due.size());
        $display("Test completed with failures");
        $finish;
    end

    // Result side: check each taken word, stall ready at random
    initial
    begin
        result_word_t got, want;
        res_bus.ready <= 1'b0;
        stall_left = 0;
        rx_steady  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            begin
                got = '{res_bus.center_valid, res_bus.is_corner, res_bus.dark_corner,
                        res_bus.center_x, res_bus.center_y};
                results_seen++;
                if (got.corner === 1'b1)
                begin
                    if (got.dark === 1'b1)
                        dark_seen++;
                    else
                        bright_seen++;
                end
                if (reports_due.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("Unexpected result word cv=%b corner=%b dark=%b x=%0d y=%0d",
                                 got.cv, got.corner, got.dark, got.cx, got.cy);
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (got.cv !== want.cv || got.corner !== want.corner ||
                        got.dark !== want.dark || got.cx !== want.cx || got.cy !== want.cy)
                    begin
                        failures++;
                        if (failures <= REPORT_MAX)
                        begin
                            $write("Result %0d mismatch: expected cv=%b corner=%b dark=%b ",
                                   results_seen, want.cv, want.corner, want.dark);
                            $display("x=%0d y=%0d, got cv=%b corner=%b dark=%b x=%0d y=%0d",
                                     want.cx, want.cy, got.cv, got.corner, got.dark,
                                     got.cx, got.cy);
                        end
                    end
                end
            end
            if ($urandom_range(0, 499) == 0)
                rx_steady = !rx_steady;
            if (stall_left > 0)
            begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus: reset, directed rows, random phases, final check
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_THRESHOLD;
        cfg_data            <= '0;
        pix_bus.valid       <= 1'b0;
        pix_bus.pixel       <= '0;
        pix_bus.frame_start <= 1'b0;
        failures     = 0;
        words_sent   = 0;
        random_words = 0;
        results_seen = 0;
        bright_seen  = 0;
        dark_seen    = 0;
        phases_run   = 0;
        tx_steady    = 1'b0;
        reset_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end
            else
            begin
                for (int n = 0; n < DIRECTED[i].count; n++)
                    send_word(DIRECTED[i].pix, DIRECTED[i].fs, DIRECTED[i].typed,
                              DIRECTED[i].want);
            end
        end

        while (random_words < RANDOM_WORDS)
            run_phase(phases_run);
        drain_results();

        if (reports_due.size() != 0)
        begin
            failures += reports_due.size();
            $display("%0d expected result words never arrived", reports_due.size());
        end
        $display("Sent %0d pixel words over %0d register settings, frames 7x7 up to 1024 wide.",
                 words_sent, phases_run + 2);
        $display("Checked %0d result words: %0d bright and %0d dark corners, %0d failures.",
                 results_seen, bright_seen, dark_seen, failures);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/fcd_pkg.sv
hw/rtl/fcd_pixel_if.sv
hw/rtl/fcd_result_if.sv
hw/rtl/fcd_front.sv
hw/rtl/fcd_window.sv
hw/rtl/fcd_arc_out.sv
hw/rtl/fast_corner_detect.sv
verif/tb_fast_corner_detect.sv
